[rtl/pomd_pkg.sv]
// package for the pdp-11 opcode mnemonic decoder
// holds the decode masks, the mnemonic codes and the result struct
// no dependencies
`default_nettype none

package pomd_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned CODE_W = 7;

    // decode masks, coarse to fine
    localparam logic [WORD_W-1:0] MASK_GRP = 16'o170000;
    localparam logic [WORD_W-1:0] MASK_M9  = 16'o177000;
    localparam logic [WORD_W-1:0] MASK_M8  = 16'o177400;
    localparam logic [WORD_W-1:0] MASK_M6  = 16'o177700;
    localparam logic [WORD_W-1:0] MASK_M5  = 16'o177740;
    localparam logic [WORD_W-1:0] MASK_M3  = 16'o177770;
    localparam logic [WORD_W-1:0] MASK_M0  = 16'o177777;

    typedef enum logic [CODE_W-1:0] {
        MN_NONE,
        MN_JSR, MN_SOB, MN_BR, MN_BNE, MN_BEQ, MN_BGE, MN_BLT, MN_BGT, MN_BLE,
        MN_JMP, MN_SWAB, MN_CLR, MN_COM, MN_INC, MN_DEC, MN_NEG, MN_ADC,
        MN_SBC, MN_TST, MN_ROR, MN_ROL, MN_ASR, MN_ASL, MN_MARK, MN_MFPI,
        MN_MTPI, MN_SXT, MN_FLAG, MN_RTS, MN_SPL, MN_HALT, MN_WAIT, MN_RTI,
        MN_BPT, MN_IOT, MN_RSET, MN_RTT, MN_MOV, MN_CMP, MN_BIT, MN_BIC,
        MN_BIS, MN_ADD, MN_MUL, MN_DIV, MN_ASH, MN_ASHC, MN_XOR, MN_FADD,
        MN_FSUB, MN_FMUL, MN_FDIV, MN_BPL, MN_BMI, MN_BHI, MN_BLOS, MN_BVC,
        MN_BVS, MN_BHIS, MN_BLO, MN_EMT, MN_SYS, MN_CLRB, MN_COMB, MN_INCB,
        MN_DECB, MN_NEGB, MN_ADCB, MN_SBCB, MN_TSTB, MN_RORB, MN_ROLB,
        MN_ASRB, MN_ASLB, MN_MFPD, MN_MTPD, MN_MOVB, MN_CMPB, MN_BITB,
        MN_BICB, MN_BISB, MN_SUB
    } t_mnem;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              recognized;
    } t_dec_result;

endpackage

`default_nettype wire

[rtl/pomd_decode.sv]
// combinational mnemonic decode of one pdp-11 instruction word
// depends on pomd_pkg for masks, codes and the result struct
`default_nettype none

module pomd_decode
    import pomd_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_word,
    output t_dec_result            o_result
);

    t_mnem c9, c8, c6, c5, c3, c0, cg, sel;

    always_comb begin
        unique case (i_word & MASK_M9)
            16'o004000: c9 = MN_JSR;
            16'o070000: c9 = MN_MUL;
            16'o071000: c9 = MN_DIV;
            16'o072000: c9 = MN_ASH;
            16'o073000: c9 = MN_ASHC;
            16'o074000: c9 = MN_XOR;
            16'o077000: c9 = MN_SOB;
            default:    c9 = MN_NONE;
        endcase
    end

    always_comb begin
        unique case (i_word & MASK_M8)
            16'o000400: c8 = MN_BR;
            16'o001000: c8 = MN_BNE;
            16'o001400: c8 = MN_BEQ;
            16'o002000: c8 = MN_BGE;
            16'o002400: c8 = MN_BLT;
            16'o003000: c8 = MN_BGT;
            16'o003400: c8 = MN_BLE;
            16'o100000: c8 = MN_BPL;
            16'o100400: c8 = MN_BMI;
            16'o101000: c8 = MN_BHI;
            16'o101400: c8 = MN_BLOS;
            16'o102000: c8 = MN_BVC;
            16'o102400: c8 = MN_BVS;
            16'o103000: c8 = MN_BHIS;
            16'o103400: c8 = MN_BLO;
            16'o104000: c8 = MN_EMT;
            16'o104400: c8 = MN_SYS;
            default:    c8 = MN_NONE;
        endcase
    end

    always_comb begin
        unique case (i_word & MASK_M6)
            16'o000100: c6 = MN_JMP;
            16'o000300: c6 = MN_SWAB;
            16'o005000: c6 = MN_CLR;
            16'o005100: c6 = MN_COM;
            16'o005200: c6 = MN_INC;
            16'o005300: c6 = MN_DEC;
            16'o005400: c6 = MN_NEG;
            16'o005500: c6 = MN_ADC;
            16'o005600: c6 = MN_SBC;
            16'o005700: c6 = MN_TST;
            16'o006000: c6 = MN_ROR;
            16'o006100: c6 = MN_ROL;
            16'o006200: c6 = MN_ASR;
            16'o006300: c6 = MN_ASL;
            16'o006400: c6 = MN_MARK;
            16'o006500: c6 = MN_MFPI;
            16'o006600: c6 = MN_MTPI;
            16'o006700: c6 = MN_SXT;
            16'o105000: c6 = MN_CLRB;
            16'o105100: c6 = MN_COMB;
            16'o105200: c6 = MN_INCB;
            16'o105300: c6 = MN_DECB;
            16'o105400: c6 = MN_NEGB;
            16'o105500: c6 = MN_ADCB;
            16'o105600: c6 = MN_SBCB;
            16'o105700: c6 = MN_TSTB;
            16'o106000: c6 = MN_RORB;
            16'o106100: c6 = MN_ROLB;
            16'o106200: c6 = MN_ASRB;
            16'o106300: c6 = MN_ASLB;
            16'o106500: c6 = MN_MFPD;
            16'o106600: c6 = MN_MTPD;
            default:    c6 = MN_NONE;
        endcase
    end

    always_comb begin
        unique case (i_word & MASK_M5)
            16'o000240: c5 = MN_FLAG;
            default:    c5 = MN_NONE;
        endcase
    end

    always_comb begin
        unique case (i_word & MASK_M3)
            16'o000200: c3 = MN_RTS;
            16'o000230: c3 = MN_SPL;
            16'o075000: c3 = MN_FADD;
            16'o075010: c3 = MN_FSUB;
            16'o075020: c3 = MN_FMUL;
            16'o075030: c3 = MN_FDIV;
            default:    c3 = MN_NONE;
        endcase
    end

    always_comb begin
        unique case (i_word & MASK_M0)
            16'o000000: c0 = MN_HALT;
            16'o000001: c0 = MN_WAIT;
            16'o000002: c0 = MN_RTI;
            16'o000003: c0 = MN_BPT;
            16'o000004: c0 = MN_IOT;
            16'o000005: c0 = MN_RSET;
            16'o000006: c0 = MN_RTT;
            default:    c0 = MN_NONE;
        endcase
    end

    always_comb begin
        unique case (i_word & MASK_GRP)
            16'o010000: cg = MN_MOV;
            16'o020000: cg = MN_CMP;
            16'o030000: cg = MN_BIT;
            16'o040000: cg = MN_BIC;
            16'o050000: cg = MN_BIS;
            16'o060000: cg = MN_ADD;
            16'o110000: cg = MN_MOVB;
            16'o120000: cg = MN_CMPB;
            16'o130000: cg = MN_BITB;
            16'o140000: cg = MN_BICB;
            16'o150000: cg = MN_BISB;
            16'o160000: cg = MN_SUB;
            default:    cg = MN_NONE;
        endcase
    end

    // first match wins, fine-grained masks in order m9 to m0 first, the group mask last
    always_comb begin
        if (c9 != MN_NONE) begin
            sel = c9;
        end else if (c8 != MN_NONE) begin
            sel = c8;
        end else if (c6 != MN_NONE) begin
            sel = c6;
        end else if (c5 != MN_NONE) begin
            sel = c5;
        end else if (c3 != MN_NONE) begin
            sel = c3;
        end else if (c0 != MN_NONE) begin
            sel = c0;
        end else begin
            sel = cg;
        end
    end

    assign o_result.code       = sel;
    assign o_result.recognized = (sel != MN_NONE);

endmodule

`default_nettype wire

[rtl/pdp11_opcode_mnemonic_decoder_unit.sv]
// top level of the pdp-11 opcode mnemonic decoder
// input register, pomd_decode, result register; depends on pomd_pkg
`default_nettype none

// Classifies one 16-bit PDP-11 instruction word per beat into a dense
// mnemonic code (0 unrecognized, 1..82 in fixed mnemonic order) plus a
// recognized flag. An accepted word is held in the input register while it
// is decoded combinationally, and its result is loaded into the result
// register when the output side advances. A new word is taken every cycle
// unless i_stall holds a waiting result: the throughput is one word per
// cycle. While a result waits, the input register can still take one more
// word if it is empty.

module pdp11_opcode_mnemonic_decoder_unit
    import pomd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [WORD_W-1:0] i_instr_word,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CODE_W-1:0]      o_mnemonic_code,
    output logic                   o_recognized
);

    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_out_valid;
    t_dec_result       r_out;
    t_dec_result       n_out;
    logic              out_adv;
    logic              in_adv;

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;

    pomd_decode u_decode (
        .i_word   (r_in_word),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_in_word <= i_instr_word;
        end
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_stall         = !in_adv;
    assign o_valid         = r_out_valid;
    assign o_mnemonic_code = r_out.code;
    assign o_recognized    = r_out.recognized;

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for pdp11_opcode_mnemonic_decoder_unit
// drives instruction words through the valid/stall handshake and checks each result beat
// against a fixed expected code or a mnemonic predictor; depends on pomd_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb;
    import pomd_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int N_CALM_TAIL = 120;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        logic [WORD_W-1:0] word;
        bit                fixed;
        t_mnem             code;
    } t_dir_row;

    localparam int N_DIR = 26;

    // fixed rows carry their answer, the others go through the predictor
    t_dir_row dir_rows [N_DIR] = '{
        '{16'o000000, 1'b1, MN_HALT},
        '{16'o177777, 1'b1, MN_NONE},
        '{16'o170000, 1'b1, MN_NONE},
        '{16'o077000, 1'b1, MN_SOB},
        '{16'o077777, 1'b1, MN_SOB},
        '{16'o076000, 1'b1, MN_NONE},
        '{16'o106400, 1'b1, MN_NONE},
        '{16'o106700, 1'b1, MN_NONE},
        '{16'o000007, 1'b1, MN_NONE},
        '{16'o075040, 1'b1, MN_NONE},
        '{16'o004000, 1'b0, MN_NONE},
        '{16'o000400, 1'b0, MN_NONE},
        '{16'o003777, 1'b0, MN_NONE},
        '{16'o000100, 1'b0, MN_NONE},
        '{16'o000377, 1'b0, MN_NONE},
        '{16'o006777, 1'b0, MN_NONE},
        '{16'o000257, 1'b0, MN_NONE},
        '{16'o000237, 1'b0, MN_NONE},
        '{16'o000006, 1'b0, MN_NONE},
        '{16'o010000, 1'b0, MN_NONE},
        '{16'o074777, 1'b0, MN_NONE},
        '{16'o075037, 1'b0, MN_NONE},
        '{16'o104777, 1'b0, MN_NONE},
        '{16'o105000, 1'b0, MN_NONE},
        '{16'o106677, 1'b0, MN_NONE},
        '{16'o167777, 1'b0, MN_NONE}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [WORD_W-1:0] i_instr_word;
    logic              o_valid;
    logic              i_stall;
    logic [CODE_W-1:0] o_mnemonic_code;
    logic              o_recognized;

    t_mnem pending_codes [$];
    int    mismatch_count;
    int    cycle_count;
    bit    idling_on;

    pdp11_opcode_mnemonic_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_instr_word    (i_instr_word),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mnemonic_code (o_mnemonic_code),
        .o_recognized    (o_recognized)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_mnem predict_mnemonic(input logic [WORD_W-1:0] w);
        t_mnem m;
        m = MN_NONE;
        case (w[15:12])
            4'd0: begin
                if (w[11:9] == 3'd4) begin
                    m = MN_JSR;
                end else if (w[11] == 1'b0 && w[10:8] != 3'd0) begin
                    m = t_mnem'(int'(MN_BR) + int'(w[10:8]) - 1);
                end else if (w[11:6] == 6'd1) begin
                    m = MN_JMP;
                end else if (w[11:6] == 6'd3) begin
                    m = MN_SWAB;
                end else if (w[11:6] >= 6'o50 && w[11:6] <= 6'o67) begin
                    m = t_mnem'(int'(MN_CLR) + int'(w[11:6]) - 'o50);
                end else if (w[11:5] == 7'o5) begin
                    m = MN_FLAG;
                end else if (w[11:3] == 9'o20) begin
                    m = MN_RTS;
                end else if (w[11:3] == 9'o23) begin
                    m = MN_SPL;
                end else if (w[11:0] <= 12'd6) begin
                    m = t_mnem'(int'(MN_HALT) + int'(w[2:0]));
                end
            end
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
                m = t_mnem'(int'(MN_MOV) + int'(w[15:12]) - 1);
            end
            4'd7: begin
                if (w[11:9] <= 3'd4) begin
                    m = t_mnem'(int'(MN_MUL) + int'(w[11:9]));
                end else if (w[11:9] == 3'd7) begin
                    m = MN_SOB;
                end else if (w[11:9] == 3'd5 && w[8:5] == 4'd0) begin
                    m = t_mnem'(int'(MN_FADD) + int'(w[4:3]));
                end
            end
            4'd8: begin
                if (w[11:8] <= 4'd9) begin
                    m = t_mnem'(int'(MN_BPL) + int'(w[11:8]));
                end else if (w[11:6] >= 6'd40 && w[11:6] <= 6'd51) begin
                    m = t_mnem'(int'(MN_CLRB) + int'(w[11:6]) - 40);
                end else if (w[11:6] == 6'd53) begin
                    m = MN_MFPD;
                end else if (w[11:6] == 6'd54) begin
                    m = MN_MTPD;
                end
            end
            4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14: begin
                m = t_mnem'(int'(MN_MOVB) + int'(w[15:12]) - 9);
            end
            default: m = MN_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                w[15:12] = 4'd0;
                if ($urandom_range(0, 1) == 0) w[5:0] = 6'($urandom_range(0, 31));
                if ($urandom_range(0, 3) == 0) w[11:6] = 6'($urandom_range(0, 3));
            end
            1: begin
                w[15:12] = 4'd7;
                if ($urandom_range(0, 1) == 0) w[8:5] = 4'd0;
            end
            2: w[15:12] = 4'd8;
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input t_mnem code);
        i_valid      <= 1'b1;
        i_instr_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_codes.push_back(code);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // result side: stall bursts
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            if (idling_on && $urandom_range(0, 1) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected result beat: mnemonic_code %0d", o_mnemonic_code);
                mismatch_count++;
            end else begin
                t_mnem want;
                want = pending_codes.pop_front();
                if (o_mnemonic_code !== want) begin
                    $error("mnemonic_code: expected %0d, got %0d", want, o_mnemonic_code);
                    mismatch_count++;
                end
                if (o_recognized !== (want != MN_NONE)) begin
                    $error("recognized: expected %0d, got %0d", want != MN_NONE,
                           o_recognized);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [WORD_W-1:0] w;
        mismatch_count = 0;
        cycle_count    = 0;
        idling_on      = 1'b1;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_instr_word   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            send_word(dir_rows[k].word,
                      dir_rows[k].fixed ? dir_rows[k].code
                                        : predict_mnemonic(dir_rows[k].word));
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            idling_on = (k < N_RANDOM - N_CALM_TAIL) && ((k / 100) % 3 != 2);
            if (k == 300) begin
                i_valid <= 1'b0;
                while (pending_codes.size() != 0) @(posedge i_clk);
            end
            w = random_word();
            send_word(w, predict_mnemonic(w));
        end
        i_valid <= 1'b0;

        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && pending_codes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
